[design/pbp_pkg.sv]
// shared types and constants for the perceptron branch predictor
package pbp_pkg;

   localparam int PC_WIDTH     = 32;
   localparam int DOT_WIDTH    = 12;
   localparam int THRESH_WIDTH = 11;
   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 11'd46;

   // row index steps: low pc half, high pc half, remainder
   localparam int IDX_STEPS     = 3;
   localparam int IDX_CNT_WIDTH = $clog2(IDX_STEPS);

   localparam logic KIND_TRAIN = 1'b1;

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_INDEX  = 8'b0000_0100,
      ST_READ   = 8'b0000_1000,
      ST_LOAD   = 8'b0001_0000,
      ST_ACCUM  = 8'b0010_0000,
      ST_RESP   = 8'b0100_0000,
      ST_UPDATE = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic req_load;
      logic idx_step;
      logic ram_rd;
      logic row_load;
      logic acc_step;
      logic rsp_load;
      logic train_wr;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic idx_last;
      logic acc_last;
      logic kind_train;
      logic rsp_free;
   } status_type;

endpackage

[design/pbp_ram.sv]
// generic single write port ram with registered read
module pbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/pbp_ctrl.sv]
// control state machine of the perceptron branch predictor
module pbp_ctrl
   import pbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = ST_INDEX;
            end
         end
         ST_INDEX: begin
            cmd.idx_step = 1'b1;
            if (status.idx_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.ram_rd = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.row_load = 1'b1;
            state_in     = status.kind_train ? ST_UPDATE : ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.acc_step = 1'b1;
            if (status.acc_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_UPDATE: begin
            cmd.train_wr = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("transaction accepted while previous one still in flight");

   a_rsp_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("result loaded over an untaken result");

   a_train_kind: assert property (@(posedge clock) disable iff (reset)
      cmd.train_wr |-> status.kind_train)
      else $error("weight update issued for a predict transaction");

endmodule

[design/pbp_dp.sv]
// datapath: index reduction, weight table, dot sum, training and result register
module pbp_dp
   import pbp_pkg::*;
#(
   parameter int TABLE_ENTRIES  = 256,
   parameter int HISTORY_LENGTH = 17,
   parameter int WEIGHT_BITS    = 7
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   output status_type                     status,
   input  logic                           req_kind,
   input  logic [PC_WIDTH-1:0]            req_pc,
   input  logic                           req_outcome,
   input  logic                           csr_wr_en,
   input  logic [THRESH_WIDTH-1:0]        csr_wr_data,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_taken,
   output logic signed [DOT_WIDTH-1:0]    rsp_dot_sum
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int H  = HISTORY_LENGTH;
   localparam int W  = WEIGHT_BITS;
   localparam int NW = H + 1;
   localparam int RW = NW * W;
   localparam int SW = $clog2(NW << (W - 1)) + 1;
   localparam int CW = ((SW > DOT_WIDTH) ? SW : DOT_WIDTH) + 1;
   localparam int KW = $clog2(H + 1);
   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam int HALF = PC_WIDTH / 2;
   localparam int MW   = PC_WIDTH + 1;
   localparam int PW   = PC_WIDTH + MW;
   localparam int PPW  = HALF + MW;
   localparam int QSH  = PC_WIDTH + AW;
   localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << QSH) / 64'(TABLE_ENTRIES)) + 64'd1);

   logic [THRESH_WIDTH-1:0] thresh_ff;
   logic [AW-1:0]           clr_cnt_ff;
   logic                    kind_ff;
   logic                    outcome_ff;
   logic [PC_WIDTH-1:0]     pc_ff;
   logic [HALF-1:0]         pc_half;
   logic [PPW-1:0]          part;
   logic [PW-1:0]           prod_ff;
   logic [PW-1:0]           prod_in;
   logic [PC_WIDTH-1:0]     quot;
   logic [PC_WIDTH-1:0]     rem_full;
   logic [AW-1:0]           rem_ff;
   logic [AW-1:0]           rem_in;
   logic [IDX_CNT_WIDTH-1:0] idx_cnt_ff;
   logic [H-1:0]            hist_ff;
   logic [H-1:0]            hist_in;
   logic [H:0]              hist_ext;
   logic [RW-1:0]           row_ff;
   logic [NW-1:0]           hist_sh_ff;
   logic [KW-1:0]           acc_cnt_ff;
   logic signed [SW-1:0]    sum_ff;
   logic signed [SW-1:0]    sum_in;
   logic signed [SW-1:0]    term;
   logic signed [SW-1:0]    base;
   logic signed [CW-1:0]    sum_ext;
   logic signed [CW-1:0]    thr_ext;
   logic                    mispredict;
   logic                    low_margin;
   logic                    train_needed;
   logic [NW-1:0]           agree;
   logic [RW-1:0]           new_row;
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [RW-1:0]           ram_wr_data;
   logic [RW-1:0]           ram_rd_data;
   logic                    rsp_valid_ff;
   logic                    rsp_taken_ff;
   logic signed [DOT_WIDTH-1:0] rsp_dot_sum_ff;

   // pc modulo table size by reciprocal multiplication, one pc half per step
   assign pc_half  = (idx_cnt_ff == '0) ? pc_ff[HALF-1:0] : pc_ff[PC_WIDTH-1:HALF];
   assign part     = PPW'(pc_half) * PPW'(RECIP);
   assign prod_in  = (idx_cnt_ff == '0) ? PW'(part) : prod_ff + (PW'(part) << HALF);
   assign quot     = PC_WIDTH'(prod_ff >> QSH);
   assign rem_full = pc_ff - quot * PC_WIDTH'(TABLE_ENTRIES);
   assign rem_in   = rem_full[AW-1:0];

   // one weight per step, bias first
   assign term = SW'(signed'(row_ff[W-1:0]));
   assign base = (acc_cnt_ff == '0) ? '0 : sum_ff;
   assign sum_in = hist_sh_ff[0] ? (base + term) : (base - term);

   assign sum_ext = {{(CW-SW){sum_ff[SW-1]}}, sum_ff};
   assign thr_ext = signed'({{(CW-THRESH_WIDTH){1'b0}}, thresh_ff});
   assign mispredict = rsp_taken_ff != outcome_ff;
   assign low_margin = (sum_ext < thr_ext) && (sum_ext > -thr_ext);
   assign train_needed = mispredict || low_margin;

   assign agree = {~(hist_ff ^ {H{outcome_ff}}), outcome_ff};

   always_comb begin
      for (int i = 0; i < NW; i++) begin
         logic signed [W-1:0] wv;
         wv = row_ff[i*W +: W];
         if (agree[i]) begin
            new_row[i*W +: W] = (wv == WMAX) ? wv : wv + W'(1);
         end else begin
            new_row[i*W +: W] = (wv == WMIN) ? wv : wv - W'(1);
         end
      end
   end

   assign hist_ext = {hist_ff, outcome_ff};
   assign hist_in  = hist_ext[H-1:0];

   assign ram_wr_en   = cmd.clear_wr || (cmd.train_wr && train_needed);
   assign ram_wr_addr = cmd.clear_wr ? clr_cnt_ff : rem_ff;
   assign ram_wr_data = cmd.clear_wr ? '0 : new_row;

   pbp_ram #(
      .WIDTH(RW),
      .DEPTH(TABLE_ENTRIES)
   ) u_weights (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (cmd.ram_rd),
      .rd_addr(rem_ff),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= THRESH_RESET;
         clr_cnt_ff   <= '0;
         hist_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_taken_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         if (cmd.train_wr) begin
            hist_ff <= hist_in;
         end
         if (cmd.acc_step) begin
            sum_ff <= sum_in;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_taken_ff <= ~sum_ff[SW-1];
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         kind_ff    <= req_kind;
         outcome_ff <= req_outcome;
         pc_ff      <= req_pc;
         idx_cnt_ff <= '0;
      end else if (cmd.idx_step) begin
         prod_ff    <= prod_in;
         rem_ff     <= rem_in;
         idx_cnt_ff <= idx_cnt_ff + IDX_CNT_WIDTH'(1);
      end
      if (cmd.row_load) begin
         row_ff     <= ram_rd_data;
         hist_sh_ff <= {hist_ff, 1'b1};
         acc_cnt_ff <= '0;
      end else if (cmd.acc_step) begin
         row_ff     <= row_ff >> W;
         hist_sh_ff <= hist_sh_ff >> 1;
         acc_cnt_ff <= acc_cnt_ff + KW'(1);
      end
      if (cmd.rsp_load) begin
         rsp_dot_sum_ff <= sum_ext[DOT_WIDTH-1:0];
      end
   end

   assign status.clear_last = clr_cnt_ff == AW'(TABLE_ENTRIES - 1);
   assign status.idx_last   = idx_cnt_ff == IDX_CNT_WIDTH'(IDX_STEPS - 1);
   assign status.acc_last   = acc_cnt_ff == KW'(H);
   assign status.kind_train = kind_ff == KIND_TRAIN;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_taken   = rsp_taken_ff;
   assign rsp_dot_sum = rsp_dot_sum_ff;

   a_sum_holds: assert property (@(posedge clock) disable iff (reset)
      !cmd.acc_step |=> $stable(sum_ff))
      else $error("kept sum changed outside accumulation");

   a_hist_shift: assert property (@(posedge clock) disable iff (reset)
      cmd.train_wr |=> hist_ff[0] == $past(outcome_ff))
      else $error("outcome not shifted into history");

   a_no_train_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_wr |-> !cmd.train_wr && !cmd.req_load)
      else $error("table activity during clearing pass");

endmodule

[design/perceptron_branch_predictor_core.sv]
// top level of the perceptron branch predictor
// Perceptron branch predictor with a table of TABLE_ENTRIES rows, each holding a bias
// and HISTORY_LENGTH history weights of WEIGHT_BITS bits, selected by pc modulo the
// table size. One transaction is in work at a time. After reset the table is
// zeroed by a clearing pass during which req_ready is low.
// Each transaction reduces the pc to a row index by reciprocal multiplication, one
// pc half per step and then the remainder, and reads the row from the weight ram;
// a predict then accumulates the dot sum one weight per cycle through one adder.
// A finished result waits in an output register, so the next transaction
// can be taken meanwhile; a predict whose result finds that register still full
// waits until it is taken.
// csr_wr_data sets the training threshold and should be written only while idle.
module perceptron_branch_predictor_core
   import pbp_pkg::*;
#(
   parameter int TABLE_ENTRIES  = 256,
   parameter int HISTORY_LENGTH = 17,
   parameter int WEIGHT_BITS    = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [PC_WIDTH-1:0]         req_pc,
   input  logic                        req_outcome,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_taken,
   output logic signed [DOT_WIDTH-1:0] rsp_dot_sum,
   input  logic                        csr_wr_en,
   input  logic [THRESH_WIDTH-1:0]     csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   pbp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   pbp_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .HISTORY_LENGTH(HISTORY_LENGTH),
      .WEIGHT_BITS   (WEIGHT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_kind   (req_kind),
      .req_pc     (req_pc),
      .req_outcome(req_outcome),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_taken  (rsp_taken),
      .rsp_dot_sum(rsp_dot_sum)
   );

endmodule

[tb/sv/tb_perceptron_branch_predictor_core.sv]
// self-checking testbench for the perceptron branch predictor core
`timescale 1ns / 1ps

module tb_perceptron_branch_predictor_core;
   import pbp_pkg::*;

   localparam int ROWS           = 256;
   localparam int HIST_LEN       = 17;
   localparam int W_BITS         = 7;
   localparam int W_MAX          = (1 << (W_BITS - 1)) - 1;
   localparam int W_MIN          = -(1 << (W_BITS - 1));
   localparam int CLK_HALF       = 10;
   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 50;
   localparam int STALL_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int IDLE_PCT       = 27;
   localparam logic KIND_PREDICT = ~KIND_TRAIN;
   localparam logic [THRESH_WIDTH-1:0] THRESH_MAX  = 11'd1151;
   localparam logic [THRESH_WIDTH-1:0] THRESH_HIGH = 11'd896;

   typedef struct {
      logic                        kind;
      logic [PC_WIDTH-1:0]         pc;
      logic                        outcome;
      bit                          fixed;
      logic                        taken;
      logic signed [DOT_WIDTH-1:0] sum;
   } branch_row_type;

   typedef struct {
      logic                        taken;
      logic signed [DOT_WIDTH-1:0] sum;
   } prediction_type;

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_kind;
   logic [PC_WIDTH-1:0]         req_pc;
   logic                        req_outcome;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic                        rsp_taken;
   logic signed [DOT_WIDTH-1:0] rsp_dot_sum;
   logic                        csr_wr_en;
   logic [THRESH_WIDTH-1:0]     csr_wr_data;

   branch_row_type offered;

   logic signed [W_BITS-1:0]    weight_tab [ROWS][HIST_LEN+1];
   logic [HIST_LEN-1:0]         branch_history;
   int                          kept_sum;
   logic                        kept_taken;
   logic [THRESH_WIDTH-1:0]     train_threshold;
   prediction_type              pending_predictions [$];

   int       mismatches = 0;
   int       quiet_cycles = 0;
   bit       steady_flow;
   bit       stall_request;
   logic [7:0] hot_rows [4];

   // untouched rows give a zero sum, predicted taken
   branch_row_type directed_rows [20] = '{
      '{KIND_TRAIN,   32'h0000_0003, 1'b1, 1'b0, 1'b0, 12'sd0},
      '{KIND_PREDICT, 32'hffff_ffff, 1'b0, 1'b1, 1'b1, 12'sd0},
      '{KIND_PREDICT, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 12'sd0},
      '{KIND_PREDICT, 32'h0000_0103, 1'b0, 1'b0, 1'b0, 12'sd0},
      '{KIND_TRAIN,   32'h0000_0103, 1'b1, 1'b0, 1'b0, 12'sd0},
      '{KIND_PREDICT, 32'hffff_ff03, 1'b1, 1'b0, 1'b0, 12'sd0},
      '{KIND_TRAIN,   32'h0000_0007, 1'b0, 1'b0, 1'b0, 12'sd0},
      '{KIND_PREDICT, 32'h0000_0007, 1'b0, 1'b0, 1'b0, 12'sd0},
      '{KIND_TRAIN,   32'haaaa_aaaa, 1'b1, 1'b0, 1'b0, 12'sd0},
      '{KIND_PREDICT, 32'h5555_5555, 1'b1, 1'b0, 1'b0, 12'sd0},
      '{KIND_TRAIN,   32'h5555_5555, 1'b0, 1'b0, 1'b0, 12'sd0},
      '{KIND_PREDICT, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 12'sd0},
      '{KIND_TRAIN,   32'h7fff_ffff, 1'b1, 1'b0, 1'b0, 12'sd0},
      '{KIND_PREDICT, 32'h7fff_ffff, 1'b0, 1'b0, 1'b0, 12'sd0},
      '{KIND_TRAIN,   32'h0000_0003, 1'b1, 1'b0, 1'b0, 12'sd0},
      '{KIND_TRAIN,   32'h0000_0003, 1'b1, 1'b0, 1'b0, 12'sd0},
      '{KIND_TRAIN,   32'h0000_0003, 1'b1, 1'b0, 1'b0, 12'sd0},
      '{KIND_PREDICT, 32'h0000_0003, 1'b0, 1'b0, 1'b0, 12'sd0},
      '{KIND_TRAIN,   32'h0000_0003, 1'b0, 1'b0, 1'b0, 12'sd0},
      '{KIND_PREDICT, 32'h0000_0003, 1'b1, 1'b0, 1'b0, 12'sd0}
   };

   assign req_kind    = offered.kind;
   assign req_pc      = offered.pc;
   assign req_outcome = offered.outcome;

   perceptron_branch_predictor_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_pc      (req_pc),
      .req_outcome (req_outcome),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_taken   (rsp_taken),
      .rsp_dot_sum (rsp_dot_sum),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   function automatic int clamp_weight(input int value);
      if (value > W_MAX) return W_MAX;
      if (value < W_MIN) return W_MIN;
      return value;
   endfunction

   // weight table, history and kept prediction follow every accepted transaction
   always @(posedge clock) begin : perceptron_predictor
      int             row;
      int             acc;
      int             limit;
      prediction_type want;
      if (reset) begin
         foreach (weight_tab[r, i]) weight_tab[r][i] = '0;
         branch_history  = '0;
         kept_sum        = 0;
         kept_taken      = 1'b0;
         train_threshold = THRESH_RESET;
      end else begin
         if (csr_wr_en) train_threshold = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (pending_predictions.size() == 0) begin
               $error("rsp transaction with no prediction pending");
               mismatches++;
            end else begin
               want = pending_predictions.pop_front();
               if (rsp_taken !== want.taken) begin
                  $error("rsp_taken: expected %0d, actual %0d", want.taken, rsp_taken);
                  mismatches++;
               end
               if (rsp_dot_sum !== want.sum) begin
                  $error("rsp_dot_sum: expected %0d, actual %0d", want.sum, rsp_dot_sum);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            row = offered.pc % ROWS;
            if (offered.kind == KIND_PREDICT) begin
               acc = int'(weight_tab[row][0]);
               for (int i = 0; i < HIST_LEN; i++) begin
                  if (branch_history[i]) acc = acc + int'(weight_tab[row][i+1]);
                  else acc = acc - int'(weight_tab[row][i+1]);
               end
               kept_sum   = acc;
               kept_taken = (acc >= 0);
               if (offered.fixed) begin
                  want.taken = offered.taken;
                  want.sum   = offered.sum;
               end else begin
                  want.taken = kept_taken;
                  want.sum   = acc[DOT_WIDTH-1:0];
               end
               pending_predictions.push_back(want);
            end else begin
               limit = int'(train_threshold);
               if ((kept_taken != offered.outcome) ||
                   (kept_sum < limit && kept_sum > -limit)) begin
                  weight_tab[row][0] = W_BITS'(clamp_weight(int'(weight_tab[row][0]) +
                                                            (offered.outcome ? 1 : -1)));
                  for (int i = 0; i < HIST_LEN; i++) begin
                     weight_tab[row][i+1] = W_BITS'(clamp_weight(int'(weight_tab[row][i+1]) +
                        ((branch_history[i] == offered.outcome) ? 1 : -1)));
                  end
               end
               branch_history = {branch_history[HIST_LEN-2:0], offered.outcome};
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_perceptron_branch_predictor_core failed");
         $finish;
      end
   end

   initial begin : receiver
      bit stall_served;
      stall_served = 1'b0;
      rsp_ready    = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (stall_request && !stall_served) begin
            rsp_ready = 1'b0;
            repeat (STALL_CYCLES) @(negedge clock);
            stall_served = 1'b1;
         end
         rsp_ready = steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   task automatic drive_branch(input branch_row_type item);
      if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 32)) @(negedge clock);
      end
      offered   = item;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic branch_row_type make_branch(input logic kind,
                                                  input logic [PC_WIDTH-1:0] pc,
                                                  input logic outcome);
      branch_row_type item;
      item.kind    = kind;
      item.pc      = pc;
      item.outcome = outcome;
      item.fixed   = 1'b0;
      item.taken   = 1'b0;
      item.sum     = '0;
      return item;
   endfunction

   // most branches land on a few hot rows so weights reach saturation
   function automatic logic [PC_WIDTH-1:0] pick_pc();
      logic [PC_WIDTH-1:0] pc;
      pc = $urandom();
      if ($urandom_range(0, 99) < 60) pc[7:0] = hot_rows[$urandom_range(0, 3)];
      return pc;
   endfunction

   // mostly a fixed direction per row, sometimes random
   function automatic logic resolve_branch(input logic [PC_WIDTH-1:0] pc);
      if ($urandom_range(0, 9) < 7) return pc[0];
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic run_branches(input int count);
      int                  issued;
      int                  pick;
      logic [PC_WIDTH-1:0] pc;
      issued = 0;
      while (issued < count) begin
         pick = $urandom_range(0, 99);
         pc   = pick_pc();
         if (pick < 75) begin
            drive_branch(make_branch(KIND_PREDICT, pc, 1'($urandom_range(0, 1))));
            drive_branch(make_branch(KIND_TRAIN, pc, resolve_branch(pc)));
            issued += 2;
         end else if (pick < 85) begin
            drive_branch(make_branch(KIND_PREDICT, pc, 1'($urandom_range(0, 1))));
            issued++;
         end else if (pick < 95) begin
            drive_branch(make_branch(KIND_TRAIN, pc, 1'($urandom_range(0, 1))));
            issued++;
         end else begin
            drive_branch(make_branch(KIND_PREDICT, pc, 1'($urandom_range(0, 1))));
            drive_branch(make_branch(KIND_TRAIN, pick_pc(), 1'($urandom_range(0, 1))));
            issued += 2;
         end
      end
   endtask

   task automatic drain_predictions();
      while (pending_predictions.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_threshold(input logic [THRESH_WIDTH-1:0] value);
      drain_predictions();
      csr_wr_data = value;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   initial begin : stimulus
      req_valid     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      offered       = make_branch(KIND_PREDICT, '0, 1'b0);
      steady_flow   = 1'b0;
      stall_request = 1'b0;
      hot_rows[0]   = 8'h00;
      hot_rows[1]   = 8'hff;
      hot_rows[2]   = 8'($urandom_range(1, 254));
      hot_rows[3]   = 8'($urandom_range(1, 254));
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[n]) drive_branch(directed_rows[n]);

      // zero threshold: only mispredicts train
      set_threshold('0);
      run_branches(220);

      // output held off while predictions keep coming
      set_threshold(THRESH_MAX);
      stall_request = 1'b1;
      run_branches(220);

      set_threshold(THRESH_HIGH);
      run_branches(220);

      set_threshold(THRESH_WIDTH'($urandom_range(1, 1150)));
      run_branches(220);

      set_threshold(THRESH_RESET);
      steady_flow = 1'b1;
      run_branches(150);
      steady_flow = 1'b0;
      run_branches(150);

      drain_predictions();
      if (mismatches == 0) begin
         $display("tb_perceptron_branch_predictor_core passed");
      end else begin
         $display("tb_perceptron_branch_predictor_core failed");
      end
      $finish;
   end

endmodule
